// ----- design/nsp_pkg.sv -----
// Shared constants, types and tables for the nearest scan point block.
`timescale 1ns / 1ps

package nsp_pkg;

    localparam int MAX_POINTS   = 4096;
    localparam int CORDIC_STEPS = 16;

    // Sample index and position counter widths.
    localparam int IDX_W  = $clog2(MAX_POINTS);
    localparam int POS_W  = $clog2(MAX_POINTS + 1);
    localparam int STEP_W = $clog2(CORDIC_STEPS);

    localparam int RANGE_W   = 16;
    localparam int OUT_IDX_W = 12;
    localparam int COORD_W   = 17;
    localparam int CFG_W     = 32;
    localparam int CFG_ADDR_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_RANGE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_RANGE   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_START_ANGLE = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_STEP  = 2'd3;

    // Inverse CORDIC gain in Q30.
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
    localparam int COORD_LIMIT = 65535;

    typedef struct packed {
        logic [RANGE_W-1:0] range;
        logic [IDX_W-1:0]   index;
    } t_job;

    // Arctangent of 2^-i in binary angle units.
    function automatic logic [29:0] atan_bau(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- design/nsp_front.sv -----
// Front end: screens range samples and tracks the nearest valid one per scan.
`timescale 1ns / 1ps

module nsp_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [nsp_pkg::RANGE_W-1:0]     i_range,
    input  logic                            i_finite,
    input  logic                            i_last,
    input  logic [nsp_pkg::RANGE_W-1:0]     i_min_range,
    input  logic [nsp_pkg::RANGE_W-1:0]     i_max_range,
    input  logic                            i_q_full,
    output logic                            o_push,
    output nsp_pkg::t_job                   o_job
);

    logic [nsp_pkg::RANGE_W-1:0] r_best_range;
    logic [nsp_pkg::IDX_W-1:0]   r_best_index;
    logic                        r_have;
    logic [nsp_pkg::POS_W-1:0]   r_pos;

    logic                        w_accept;
    logic                        w_in_window;
    logic                        w_take;
    logic [nsp_pkg::RANGE_W-1:0] n_best_range;
    logic [nsp_pkg::IDX_W-1:0]   n_best_index;
    logic                        n_have;

    assign o_ready  = !i_q_full;
    assign w_accept = i_valid && o_ready;

    assign w_in_window = r_pos < nsp_pkg::POS_W'(nsp_pkg::MAX_POINTS);
    assign w_take = w_in_window && i_finite && (i_range >= i_min_range)
                    && (i_range <= i_max_range) && (!r_have || i_range < r_best_range);

    assign n_best_range = w_take ? i_range : r_best_range;
    assign n_best_index = w_take ? r_pos[nsp_pkg::IDX_W-1:0] : r_best_index;
    assign n_have       = r_have || w_take;

    // The scan result leaves on the last sample, judged together with it.
    assign o_push      = w_accept && i_last && n_have;
    assign o_job.range = n_best_range;
    assign o_job.index = n_best_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_range <= '0;
            r_best_index <= '0;
            r_have       <= 1'b0;
            r_pos        <= '0;
        end else if (w_accept) begin
            if (i_last) begin
                r_best_range <= '0;
                r_best_index <= '0;
                r_have       <= 1'b0;
                r_pos        <= '0;
            end else begin
                r_best_range <= n_best_range;
                r_best_index <= n_best_index;
                r_have       <= n_have;
                if (w_in_window) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

endmodule

// ----- design/nsp_queue.sv -----
// Two-entry queue of finished scan jobs between the front and back ends.
`timescale 1ns / 1ps

module nsp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nsp_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output nsp_pkg::t_job o_job
);

    nsp_pkg::t_job r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- design/nsp_back.sv -----
// Back end: beam angle, iterative CORDIC rotation, rounding and output register.
`timescale 1ns / 1ps

module nsp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  nsp_pkg::t_job               i_job,
    output logic                        o_pop,
    input  logic [31:0]                 i_start_angle,
    input  logic [30:0]                 i_angle_step,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [63:0]                 o_data
);

    localparam int CW = 34;
    localparam int PW = nsp_pkg::IDX_W + 31;
    localparam int XW = nsp_pkg::IDX_W + nsp_pkg::OUT_IDX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_ROT,
        ST_ROUND
    } t_state;

    t_state                        r_state;
    logic [nsp_pkg::RANGE_W-1:0]   r_range;
    logic [nsp_pkg::IDX_W-1:0]     r_index;
    logic [PW-1:0]                 r_prod;
    logic [29:0]                   r_xg;
    logic signed [CW-1:0]          r_x;
    logic signed [CW-1:0]          r_y;
    logic signed [CW-1:0]          r_z;
    logic [nsp_pkg::STEP_W-1:0]    r_step;
    logic                          r_out_valid;
    logic [63:0]                   r_out_data;

    logic [31:0]          w_angle;
    logic [31:0]          w_quarter;
    logic                 w_fold;
    logic [31:0]          w_z0;
    logic signed [CW-1:0] w_xg;
    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;
    logic signed [CW-1:0] w_atan;
    logic [45:0]          w_gain_prod;
    logic                 w_slot_free;
    logic                 w_emit;
    logic [nsp_pkg::COORD_W-1:0] w_px;
    logic [nsp_pkg::COORD_W-1:0] w_py;
    logic [XW-1:0]        w_index_ext;

    // Clamp a Q14 value rounded to millimeters into the output range.
    function automatic logic [nsp_pkg::COORD_W-1:0] to_mm(input logic signed [CW-1:0] q);
        logic signed [CW-1:0] r;
        logic [nsp_pkg::COORD_W-1:0] v;
        r = (q + CW'(8192)) >>> 14;
        if (r > CW'(nsp_pkg::COORD_LIMIT)) begin
            v = nsp_pkg::COORD_W'(nsp_pkg::COORD_LIMIT);
        end else if (r < -CW'(nsp_pkg::COORD_LIMIT)) begin
            v = nsp_pkg::COORD_W'(-nsp_pkg::COORD_LIMIT);
        end else begin
            v = r[nsp_pkg::COORD_W-1:0];
        end
        return v;
    endfunction

    assign o_pop       = (r_state == ST_IDLE) && !i_q_empty;
    assign w_gain_prod = 46'(i_job.range) * 46'(nsp_pkg::INV_GAIN_Q30);

    // Fold the angle into the right half plane; a half turn negates the vector.
    assign w_angle   = i_start_angle + r_prod[31:0];
    assign w_quarter = w_angle + 32'h4000_0000;
    assign w_fold    = w_quarter[31];
    assign w_z0      = w_fold ? (w_angle + 32'h8000_0000) : w_angle;
    assign w_xg      = signed'(CW'(r_xg));

    assign w_dx   = r_y >>> r_step;
    assign w_dy   = r_x >>> r_step;
    assign w_atan = signed'(CW'(nsp_pkg::atan_bau(5'(r_step))));

    assign w_slot_free = !r_out_valid || i_ready;
    assign w_emit      = (r_state == ST_ROUND) && w_slot_free;
    assign w_px        = to_mm(r_x);
    assign w_py        = to_mm(r_y);
    assign w_index_ext = XW'(r_index);

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_range <= i_job.range;
                        r_index <= i_job.index;
                        r_prod  <= PW'(i_job.index) * PW'(i_angle_step);
                        r_xg    <= w_gain_prod[45:16];
                        r_state <= ST_ANGLE;
                    end
                end
                ST_ANGLE: begin
                    r_x     <= w_fold ? -w_xg : w_xg;
                    r_y     <= '0;
                    r_z     <= signed'({{(CW-32){w_z0[31]}}, w_z0});
                    r_step  <= '0;
                    r_state <= ST_ROT;
                end
                ST_ROT: begin
                    if (!r_z[CW-1]) begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - w_atan;
                    end else begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + w_atan;
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == nsp_pkg::STEP_W'(nsp_pkg::CORDIC_STEPS - 1)) begin
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    if (w_slot_free) begin
                        r_out_data  <= {2'b00, w_index_ext[nsp_pkg::OUT_IDX_W-1:0],
                                        r_range, w_py, w_px};
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- design/nearest_scan_point_to_xy.sv -----
// Top level of the nearest scan point block: registers, front, queue and back end.
//
//  Channel  | Direction | Handshake             | Payload
//  ---------+-----------+-----------------------+------------------------------------------
//  samples  | in        | s_axis tvalid/tready  | tdata range, tuser finite, tlast scan end
//  points   | out       | m_axis tvalid/tready  | tdata x, y, nearest range, nearest index
//  config   | in        | cfg_we                | cfg_addr register, cfg_data value
//
// Samples are taken one per cycle while the queue is not full; the front end does one compare and update each.
// Each scan with a valid sample passes through the back end's angle, rotation and rounding states
// one at a time in the single iterative CORDIC unit; up to two finished scans wait in the queue.
// The sample input stalls only while that queue is full.
// Reset is synchronous and active low and clears the scan state, the queue and the output.
`timescale 1ns / 1ps

module nearest_scan_point_to_xy (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [15:0]                       i_s_axis_tdata,  // range_sample
    input  logic                              i_s_axis_tuser,  // sample_finite
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // point_x[16:0], point_y[33:17], nearest_range[49:34], nearest_index[61:50], zero pad
    output logic [63:0]                       o_m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [nsp_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [nsp_pkg::CFG_W-1:0]         i_cfg_data
);

    logic [15:0]   r_min_range;
    logic [15:0]   r_max_range;
    logic [31:0]   r_start_angle;
    logic [30:0]   r_angle_step;

    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    nsp_pkg::t_job w_push_job;
    nsp_pkg::t_job w_head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range   <= 16'd0;
            r_max_range   <= 16'hFFFF;
            r_start_angle <= 32'd0;
            r_angle_step  <= 31'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                nsp_pkg::REG_MIN_RANGE:   r_min_range   <= i_cfg_data[15:0];
                nsp_pkg::REG_MAX_RANGE:   r_max_range   <= i_cfg_data[15:0];
                nsp_pkg::REG_START_ANGLE: r_start_angle <= i_cfg_data[31:0];
                nsp_pkg::REG_ANGLE_STEP:  r_angle_step  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    nsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_range     (i_s_axis_tdata),
        .i_finite    (i_s_axis_tuser),
        .i_last      (i_s_axis_tlast),
        .i_min_range (r_min_range),
        .i_max_range (r_max_range),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    nsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_job   (w_head_job)
    );

    nsp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_empty),
        .i_job         (w_head_job),
        .o_pop         (w_pop),
        .i_start_angle (r_start_angle),
        .i_angle_step  (r_angle_step),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_data        (o_m_axis_tdata)
    );

endmodule
